>>> rtl/fsrc_pkg.sv
// Shared types, constants and pointer helpers for the frame slot ring cache.
// No dependencies; every other file imports this package.
package fsrc_pkg;

	localparam int SLOTS  = 8;
	localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;
	localparam int TAG_W  = 64;

	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [SLOT_W-1:0] ptr_t;
	typedef logic [FILL_W-1:0] fill_t;

	localparam tag_t NO_STAMP = '1;

	typedef enum logic [2:0] {
		CMD_ALLOC    = 3'd0,
		CMD_VALIDATE = 3'd1,
		CMD_INVAL    = 3'd2,
		CMD_FLUSH    = 3'd3,
		CMD_FIND     = 3'd4,
		CMD_AFTER    = 3'd5,
		CMD_BEFORE   = 3'd6,
		CMD_NEWEST   = 3'd7
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NONE   = 2'd1,
		ST_MISUSE = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_FIN
	} state_e;

	// Per-cell control: clear to untagged, shift toward cell 0, load write data.
	typedef struct packed {
		logic clr;
		logic rot;
		logic wr;
	} cell_ctl_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (p == ptr_t'(SLOTS - 1)) r = '0;
		else r = p + ptr_t'(1);
		return r;
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		ptr_t r;
		if (p == '0) r = ptr_t'(SLOTS - 1);
		else r = p - ptr_t'(1);
		return r;
	endfunction

endpackage

>>> rtl/fsrc_intf.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on fsrc_pkg for field widths.
interface fsrc_cmd_if import fsrc_pkg::*; ;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [2:0] slot;
	tag_t       stamp;

	modport source (output valid, command, slot, stamp, input ready);
	modport sink (input valid, command, slot, stamp, output ready);
endinterface

interface fsrc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] slot_out;
	logic       evicted;

	modport source (output valid, status, slot_out, evicted, input ready);
	modport sink (input valid, status, slot_out, evicted, output ready);
endinterface

>>> rtl/fsrc_cell.sv
// One slot cell of the tag ring: holds a 64-bit tag, shifts from its neighbor.
// Depends on fsrc_pkg.
module fsrc_cell import fsrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  tag_t      nbr_tag,
	input  tag_t      wr_tag,
	output tag_t      tag,
	output logic      none
);

	tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= NO_STAMP;
		end else if (ctl.clr) begin
			tag_q <= NO_STAMP;
		end else if (ctl.rot) begin
			tag_q <= nbr_tag;
		end else if (ctl.wr) begin
			tag_q <= wr_tag;
		end
	end

	assign tag  = tag_q;
	assign none = (tag_q == NO_STAMP);

endmodule

>>> rtl/frame_slot_ring_cache_core.sv
// Frame slot ring cache: a ring of SLOTS tag cells with a command controller.
// Depends on fsrc_pkg, fsrc_intf (channel interfaces) and fsrc_cell.
//
// One command at a time. Allocate, validate, invalidate, flush and newest go
// from the held command beat through the exec state to the output register.
// Find exact, find after and find before walk: the tag ring rotates one full
// turn through the comparator at cell 0, one slot per cycle, and comes back to
// its home position. A new command beat is taken while a result still waits on
// the output register; results leave through that register in command order.
module frame_slot_ring_cache_core import fsrc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	fsrc_cmd_if.sink       cmd,
	fsrc_res_if.source     res
);

	state_e state_q, state_d;

	logic [2:0] cmd_q;
	logic [2:0] slot_q;
	tag_t       stamp_q;

	ptr_t  oldest_q, next_q;
	fill_t fill_q;

	ptr_t  step_q;
	logic  found_q;
	logic  hit_misuse_q;
	ptr_t  best_ord_q;
	ptr_t  best_phys_q;

	logic       res_valid_q;
	logic [1:0] status_q;
	logic [2:0] slot_out_q;
	logic       evicted_q;

	tag_t cell_tag  [SLOTS];
	logic cell_none [SLOTS];

	logic accept, out_free, exec_go, fin_go, walk_rot, flush_go, wr_alloc, wr_valid;
	logic empty, full, slot_in_range, is_search;
	logic [IDX_W-1:0] slot_wide;
	ptr_t slot_idx, prev_ptr, base_old, base_next;
	tag_t wr_tag;

	status_e    ex_status;
	logic [2:0] ex_slot;
	logic       ex_ev;
	status_e    fin_status;
	logic [2:0] fin_slot;

	ptr_t  ord;
	logic  elig, ev_hit, ev_misuse, take;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE);

	assign is_search = (cmd.command == CMD_FIND) || (cmd.command == CMD_AFTER) ||
		(cmd.command == CMD_BEFORE);

	assign empty     = (fill_q == '0);
	assign full      = (fill_q == fill_t'(SLOTS));
	assign base_old  = empty ? '0 : oldest_q;
	assign base_next = empty ? '0 : next_q;
	assign prev_ptr  = ptr_dec(next_q);

	assign slot_wide     = IDX_W'(slot_q);
	assign slot_idx      = slot_wide[SLOT_W-1:0];
	assign slot_in_range = (32'(slot_q) < 32'(SLOTS));

	// Single-step commands: result and state update from the latched beat
	always_comb begin
		ex_status = ST_OK;
		ex_slot   = '0;
		ex_ev     = 1'b0;
		case (cmd_q)
			CMD_ALLOC: begin
				ex_slot = 3'(base_next);
				ex_ev   = full;
			end
			CMD_VALIDATE: begin
				if (slot_in_range && cell_none[slot_idx]) ex_slot = slot_q;
				else ex_status = ST_MISUSE;
			end
			CMD_INVAL: begin
				if (!empty && slot_wide == IDX_W'(prev_ptr) && cell_none[prev_ptr])
					ex_slot = 3'(prev_ptr);
				else ex_status = ST_MISUSE;
			end
			CMD_FLUSH: ex_slot = '0;
			CMD_NEWEST: begin
				if (empty) ex_status = ST_NONE;
				else ex_slot = 3'(prev_ptr);
			end
			default: ex_status = ST_NONE;
		endcase
	end

	assign exec_go  = (state_q == S_EXEC) && out_free;
	assign fin_go   = (state_q == S_FIN) && out_free;
	assign walk_rot = (state_q == S_WALK);
	assign flush_go = exec_go && (cmd_q == CMD_FLUSH);
	assign wr_alloc = exec_go && (cmd_q == CMD_ALLOC);
	assign wr_valid = exec_go && (cmd_q == CMD_VALIDATE) && (ex_status == ST_OK);
	assign wr_tag   = wr_alloc ? NO_STAMP : stamp_q;

	// Walk: cell 0 holds physical slot step_q; rank it from the oldest slot
	always_comb begin
		ord = step_q - oldest_q;
		if (step_q < oldest_q) ord = step_q + ptr_t'(SLOTS) - oldest_q;
	end

	always_comb begin
		elig      = 1'b0;
		ev_misuse = 1'b0;
		ev_hit    = 1'b0;
		case (cmd_q)
			CMD_FIND: begin
				elig   = (stamp_q != NO_STAMP) && (FILL_W'(ord) < fill_q);
				ev_hit = (cell_tag[0] == stamp_q);
			end
			CMD_AFTER: begin
				elig      = (FILL_W'(ord) + fill_t'(1) < fill_q);
				ev_misuse = cell_none[0];
				ev_hit    = (cell_tag[0] == stamp_q);
			end
			CMD_BEFORE: begin
				elig      = (ord != '0) && (FILL_W'(ord) < fill_q);
				ev_misuse = cell_none[0];
				ev_hit    = (cell_tag[0] == stamp_q);
			end
			default: elig = 1'b0;
		endcase
		take = walk_rot && elig && (ev_misuse || ev_hit) && (!found_q || ord < best_ord_q);
	end

	always_comb begin
		fin_status = ST_NONE;
		fin_slot   = '0;
		if (found_q) begin
			if (hit_misuse_q) begin
				fin_status = ST_MISUSE;
			end else begin
				fin_status = ST_OK;
				case (cmd_q)
					CMD_AFTER:  fin_slot = 3'(ptr_inc(best_phys_q));
					CMD_BEFORE: fin_slot = 3'(ptr_dec(best_phys_q));
					default:    fin_slot = 3'(best_phys_q);
				endcase
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = is_search ? S_WALK : S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			S_WALK: begin
				if (step_q == ptr_t'(SLOTS - 1)) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Hold the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd.command;
			slot_q  <= cmd.slot;
			stamp_q <= cmd.stamp;
		end
	end

	// Ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			next_q   <= '0;
			fill_q   <= '0;
		end else if (flush_go) begin
			oldest_q <= '0;
			next_q   <= '0;
			fill_q   <= '0;
		end else if (wr_alloc) begin
			next_q <= ptr_inc(base_next);
			if (full) begin
				oldest_q <= ptr_inc(base_old);
			end else begin
				oldest_q <= base_old;
				fill_q   <= fill_q + fill_t'(1);
			end
		end else if (exec_go && cmd_q == CMD_INVAL && ex_status == ST_OK) begin
			next_q <= prev_ptr;
			fill_q <= fill_q - fill_t'(1);
		end
	end

	// Walk bookkeeping: earliest event in oldest-to-newest order wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			step_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (walk_rot) step_q <= step_q + ptr_t'(1);
			if (take) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_ord_q   <= ord;
			best_phys_q  <= step_q;
			hit_misuse_q <= ev_misuse;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_go || fin_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q   <= ex_status;
			slot_out_q <= (ex_status == ST_OK) ? ex_slot : '0;
			evicted_q  <= ex_ev;
		end else if (fin_go) begin
			status_q   <= fin_status;
			slot_out_q <= fin_slot;
			evicted_q  <= 1'b0;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.status   = status_q;
	assign res.slot_out = slot_out_q;
	assign res.evicted  = evicted_q;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.clr = flush_go;
		assign ctl.rot = walk_rot;
		assign ctl.wr  = (wr_alloc && base_next == ptr_t'(k)) ||
			(wr_valid && slot_idx == ptr_t'(k));

		fsrc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.nbr_tag (cell_tag[(k + 1) % SLOTS]),
			.wr_tag  (wr_tag),
			.tag     (cell_tag[k]),
			.none    (cell_none[k])
		);
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= SLOTS)
		else $error("fill count above ring size");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (oldest_q == next_q))
		else $error("full ring with pointers apart");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_FIN))
		else $error("result raised outside exec or finish");

	a_walk_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (step_q == '0 || SLOTS != (1 << SLOT_W)))
		else $error("ring walk did not complete a full turn");

endmodule

>>> tb/frame_slot_ring_cache_core_test.sv
// Self-checking testbench for frame_slot_ring_cache_core: random command beats
// against a behavioral model of the slot ring, with random stalls on both channels.
// Depends on fsrc_pkg, fsrc_intf and the core RTL.
module frame_slot_ring_cache_core_test;
	import fsrc_pkg::*;

	localparam int ITEMS = 1100;

	typedef struct {
		cmd_e       op;
		logic [2:0] slot;
		tag_t       stamp;
		bit         aim_slot;   // take the newest slot of the ring when driven
		bit         aim_stamp;  // take a live slot's tag when driven
	} order_t;

	typedef struct packed {
		status_e    status;
		logic [2:0] slot_out;
		logic       evicted;
	} result_t;

	logic clk;
	logic arst_n;

	fsrc_cmd_if cmd_ch ();
	fsrc_res_if res_ch ();

	frame_slot_ring_cache_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Ring as the block should hold it.
	tag_t ring_tag [SLOTS];
	int   ring_oldest;
	int   ring_next;
	int   ring_fill;

	order_t  pending_q [$];
	result_t due_results [$];

	int err_count = 0;
	bit cmd_taken = 1'b0;
	bit res_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	bit quiet_cmd = 1'b0;
	bit quiet_res = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void ring_clear();
		for (int i = 0; i < SLOTS; i++) ring_tag[i] = NO_STAMP;
		ring_oldest = 0;
		ring_next = 0;
		ring_fill = 0;
	endfunction

	function automatic result_t answer(status_e st, int idx, bit ev);
		result_t r;
		r.status = st;
		r.slot_out = (st == ST_OK) ? 3'(idx) : 3'd0;
		r.evicted = ev;
		return r;
	endfunction

	function automatic result_t ring_command(cmd_e op, logic [2:0] slot, tag_t stamp);
		int i;
		int idx;
		int prev;
		bit ev;
		ev = 1'b0;
		case (op)
			CMD_ALLOC: begin
				if (ring_fill == 0) begin
					ring_oldest = 0;
					ring_next = 0;
				end
				if (ring_fill >= SLOTS) begin
					ring_oldest = (ring_oldest + 1) % SLOTS;
					ev = 1'b1;
				end else begin
					ring_fill++;
				end
				idx = ring_next;
				ring_tag[idx] = NO_STAMP;
				ring_next = (ring_next + 1) % SLOTS;
				return answer(ST_OK, idx, ev);
			end
			CMD_VALIDATE: begin
				if (int'(slot) >= SLOTS || ring_tag[slot] != NO_STAMP)
					return answer(ST_MISUSE, 0, 1'b0);
				ring_tag[slot] = stamp;
				return answer(ST_OK, int'(slot), 1'b0);
			end
			CMD_INVAL: begin
				prev = (ring_next + SLOTS - 1) % SLOTS;
				if (ring_fill == 0 || int'(slot) != prev || ring_tag[prev] != NO_STAMP)
					return answer(ST_MISUSE, 0, 1'b0);
				ring_next = prev;
				ring_fill--;
				return answer(ST_OK, prev, 1'b0);
			end
			CMD_FLUSH: begin
				ring_clear();
				return answer(ST_OK, 0, 1'b0);
			end
			CMD_FIND: begin
				if (stamp == NO_STAMP) return answer(ST_NONE, 0, 1'b0);
				for (i = 0; i < ring_fill; i++) begin
					idx = (ring_oldest + i) % SLOTS;
					if (ring_tag[idx] == stamp) return answer(ST_OK, idx, 1'b0);
				end
				return answer(ST_NONE, 0, 1'b0);
			end
			CMD_AFTER: begin
				// newest slot is never compared; an untagged slot ends the walk
				for (i = 0; i + 1 < ring_fill; i++) begin
					idx = (ring_oldest + i) % SLOTS;
					if (ring_tag[idx] == NO_STAMP) return answer(ST_MISUSE, 0, 1'b0);
					if (ring_tag[idx] == stamp)
						return answer(ST_OK, (idx + 1) % SLOTS, 1'b0);
				end
				return answer(ST_NONE, 0, 1'b0);
			end
			CMD_BEFORE: begin
				for (i = 1; i < ring_fill; i++) begin
					idx = (ring_oldest + i) % SLOTS;
					if (ring_tag[idx] == NO_STAMP) return answer(ST_MISUSE, 0, 1'b0);
					if (ring_tag[idx] == stamp)
						return answer(ST_OK, (idx + SLOTS - 1) % SLOTS, 1'b0);
				end
				return answer(ST_NONE, 0, 1'b0);
			end
			default: begin
				if (ring_fill == 0) return answer(ST_NONE, 0, 1'b0);
				return answer(ST_OK, (ring_next + SLOTS - 1) % SLOTS, 1'b0);
			end
		endcase
	endfunction

	function automatic void flag_error(string msg);
		err_count++;
		if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
	endfunction

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic tag_t draw_stamp();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return NO_STAMP;
			2: return NO_STAMP - tag_t'(1);
			3: return tag_t'(1) << $urandom_range(0, TAG_W - 1);
			4: return ~(tag_t'(1) << $urandom_range(0, TAG_W - 1));
			5, 6, 7: return tag_t'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void queue_order(cmd_e op, logic [2:0] slot, tag_t stamp,
			bit aim_slot = 1'b0, bit aim_stamp = 1'b0);
		order_t o;
		o.op = op;
		o.slot = slot;
		o.stamp = stamp;
		o.aim_slot = aim_slot;
		o.aim_stamp = aim_stamp;
		pending_q.push_back(o);
	endfunction

	// Command driver: present one beat at a time, with a drawn gap after each.
	always @(negedge clk) begin
		logic   load_valid;
		order_t cur;
		if (arst_n) begin
			load_valid = cmd_ch.valid;
			if (cmd_taken) begin
				cmd_taken = 1'b0;
				load_valid = 1'b0;
				if ($urandom_range(0, 39) == 0) quiet_cmd = !quiet_cmd;
				send_gap = draw_wait(quiet_cmd);
			end
			if (!load_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_q.size() != 0) begin
					cur = pending_q.pop_front();
					// resolve against the ring as it stands after all earlier beats
					if (cur.aim_slot) cur.slot = 3'((ring_next + SLOTS - 1) % SLOTS);
					if (cur.aim_stamp && ring_fill > 0)
						cur.stamp = ring_tag[(ring_oldest +
							$urandom_range(0, ring_fill - 1)) % SLOTS];
					cmd_ch.command <= cur.op;
					cmd_ch.slot <= cur.slot;
					cmd_ch.stamp <= cur.stamp;
					load_valid = 1'b1;
				end
			end
			cmd_ch.valid <= load_valid;
		end
	end

	// Result sink: hold ready low for a drawn stall after each beat.
	always @(negedge clk) begin
		logic nxt_ready;
		if (arst_n) begin
			if (res_taken) begin
				res_taken = 1'b0;
				if ($urandom_range(0, 39) == 0) quiet_res = !quiet_res;
				stall_left = draw_wait(quiet_res);
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			res_ch.ready <= nxt_ready;
		end
	end

	// Monitor: check result beats, then predict from command beats.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				res_taken = 1'b1;
				if (due_results.size() == 0) begin
					flag_error($sformatf("result with nothing due: status %0d slot %0d evicted %0b",
						res_ch.status, res_ch.slot_out, res_ch.evicted));
				end else begin
					want = due_results.pop_front();
					if (res_ch.status !== want.status || res_ch.slot_out !== want.slot_out ||
							res_ch.evicted !== want.evicted)
						flag_error($sformatf({"result mismatch: expected status %0d slot %0d ",
							"evicted %0b, got status %0d slot %0d evicted %0b"},
							want.status, want.slot_out, want.evicted,
							res_ch.status, res_ch.slot_out, res_ch.evicted));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmd_taken = 1'b1;
				due_results.push_back(ring_command(cmd_e'(cmd_ch.command), cmd_ch.slot,
					cmd_ch.stamp));
			end
		end
	end

	initial begin
		int pick;
		int run;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_ALLOC;
		cmd_ch.slot = '0;
		cmd_ch.stamp = '0;
		res_ch.ready = 1'b0;
		ring_clear();

		// empty ring answers
		queue_order(CMD_NEWEST, 3'd0, '0);
		queue_order(CMD_FIND, 3'd0, '0);
		queue_order(CMD_AFTER, 3'd7, NO_STAMP);
		queue_order(CMD_BEFORE, 3'd0, '0);
		queue_order(CMD_INVAL, 3'd0, '0);
		// take back a fresh allocation
		queue_order(CMD_ALLOC, 3'd7, NO_STAMP);
		queue_order(CMD_INVAL, 3'd0, '0, 1'b1);
		// tag it, then misuse validate and invalidate on a tagged slot
		queue_order(CMD_ALLOC, 3'd0, '0);
		queue_order(CMD_VALIDATE, 3'd0, '0, 1'b1);
		queue_order(CMD_VALIDATE, 3'd0, NO_STAMP - tag_t'(1), 1'b1);
		queue_order(CMD_INVAL, 3'd0, '0, 1'b1);
		// validate with none leaves the slot untagged
		queue_order(CMD_ALLOC, 3'd0, '0);
		queue_order(CMD_VALIDATE, 3'd0, NO_STAMP, 1'b1);
		queue_order(CMD_FIND, 3'd0, NO_STAMP);
		queue_order(CMD_AFTER, 3'd0, '0);
		queue_order(CMD_BEFORE, 3'd0, '0);
		queue_order(CMD_FIND, 3'd0, '0);
		queue_order(CMD_NEWEST, 3'd0, '0);
		// wrap the ring and evict
		for (int i = 0; i < SLOTS; i++) queue_order(CMD_ALLOC, 3'(i), draw_stamp());
		queue_order(CMD_FLUSH, 3'd7, NO_STAMP);
		queue_order(CMD_ALLOC, 3'd5, '0);

		while (pending_q.size() < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				queue_order(CMD_ALLOC, 3'($urandom), draw_stamp());
				queue_order(CMD_VALIDATE, 3'd0, draw_stamp(), 1'b1);
			end else if (pick < 55) begin
				queue_order(cmd_e'($urandom_range(CMD_FIND, CMD_BEFORE)), 3'($urandom),
					draw_stamp(), 1'b0, 1'b1);
			end else if (pick < 60) begin
				queue_order(cmd_e'($urandom_range(CMD_FIND, CMD_BEFORE)), 3'($urandom),
					draw_stamp());
			end else if (pick < 65) begin
				queue_order(CMD_NEWEST, 3'($urandom), draw_stamp());
			end else if (pick < 72) begin
				run = $urandom_range(1, 10);
				repeat (run) queue_order(CMD_ALLOC, 3'($urandom), draw_stamp());
			end else if (pick < 77) begin
				// unwind untagged allocations, possibly down to an empty ring
				run = $urandom_range(1, SLOTS);
				repeat (run) queue_order(CMD_INVAL, 3'd0, draw_stamp(), 1'b1);
			end else if (pick < 82) begin
				queue_order(CMD_VALIDATE, 3'($urandom), draw_stamp());
			end else if (pick < 85) begin
				queue_order(CMD_INVAL, 3'($urandom), draw_stamp());
			end else if (pick < 87) begin
				queue_order(CMD_FLUSH, 3'($urandom), draw_stamp());
			end else begin
				queue_order(cmd_e'($urandom_range(0, 7)), 3'($urandom), draw_stamp());
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_q.size() != 0 || cmd_ch.valid || due_results.size() != 0);
		// let any stray result show up
		repeat (SLOTS + 12) @(posedge clk);
		if (due_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", due_results.size()));

		if (err_count == 0) begin
			$display("frame_slot_ring_cache_core regression: pass");
		end else begin
			$display("frame_slot_ring_cache_core regression: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("frame_slot_ring_cache_core regression: fail");
		$finish;
	end

endmodule
